FILE: src/pfa_pkg.sv
// Package for the partition fit allocator: request and result structs,
// function and strategy codes, configuration register indexes.
// No dependencies.
`default_nettype none

package pfa_pkg;

    localparam int AMT_W      = 20;
    localparam int SLOT_W     = 4;
    localparam int FUNC_W     = 2;
    localparam int STRAT_W    = 3;
    localparam int COUNT_W    = 5;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;

    // Function codes of a request
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

    // Placement strategies; unused codes behave as first fit
    localparam logic [STRAT_W-1:0] STRAT_FIRST = 3'd0;
    localparam logic [STRAT_W-1:0] STRAT_BEST  = 3'd1;
    localparam logic [STRAT_W-1:0] STRAT_WORST = 3'd2;
    localparam logic [STRAT_W-1:0] STRAT_NEXT  = 3'd3;
    localparam logic [STRAT_W-1:0] STRAT_LAST  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_STRATEGY = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COUNT    = 1'd1;

    localparam logic [STRAT_W-1:0] STRATEGY_RESET = STRAT_FIRST;
    localparam logic [COUNT_W-1:0] COUNT_RESET    = 5'd16;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] slot;
        logic [AMT_W-1:0]  amount;
    } in_item_t;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] chosen_partition;
        logic [AMT_W-1:0]  remaining_after;
    } out_item_t;

endpackage

`default_nettype wire

FILE: src/pfa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module pfa_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: src/partition_fit_allocator.sv
// Partition fit allocator: an allocate scans the n partitions in use (n = 16 at reset), one
// RAM read a cycle; its result goes to the output register after the scan, and the next request
// is taken only once that result has entered that register. Other requests, and allocates with
// none in use, skip the scan. Reset (synchronous, aresetn low) clears control state and per-entry
// flags; both tables then read as zero without a clearing pass. Restart takes effect by flag.
// Depends on pfa_pkg and pfa_ram.
`default_nettype none

module partition_fit_allocator #(
    parameter int MAX_PARTITIONS = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire pfa_pkg::in_item_t                  s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output pfa_pkg::out_item_t                      m_data,
    input  wire logic                               cfg_we,
    input  wire logic [pfa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [pfa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    import pfa_pkg::*;

    localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_RESP  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [STRAT_W-1:0]        strategy_reg, strategy_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic [MAX_PARTITIONS-1:0] size_vld_reg, size_vld_next;
    logic [MAX_PARTITIONS-1:0] rem_sel_reg, rem_sel_next;
    logic [IDX_W-1:0]          next_ptr_reg, next_ptr_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic                      found_vld_reg, found_vld_next;
    logic                      out_vld_reg, out_vld_next;

    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]  issued_reg, issued_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]  found_idx_reg, found_idx_next;
    logic [AMT_W-1:0]  found_val_reg, found_val_next;
    logic [AMT_W-1:0]  amount_reg, amount_next;
    out_item_t         res_reg, res_next;
    out_item_t         out_data_reg, out_data_next;

    logic              in_acc;
    logic              load_hit;
    logic [IDX_W-1:0]  slot_idx;
    logic [CNT_W-1:0]  n_in;
    logic [IDX_W-1:0]  start_idx;
    logic              issue;
    logic              wb_en;
    logic [AMT_W-1:0]  wb_val;
    logic [AMT_W-1:0]  size_rd, rem_rd, cur_val;
    logic              fits, take;

    logic              size_we, rem_we;
    logic [IDX_W-1:0]  rem_waddr;
    logic [AMT_W-1:0]  rem_wdata;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_acc  = s_valid && s_ready;
    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

    assign slot_idx = IDX_W'(s_data.slot);
    assign load_hit = in_acc && (s_data.func == FUNC_LOAD)
                      && (32'(s_data.slot) < MAX_PARTITIONS);

    // Partitions in use, saturated at the table depth
    assign n_in = (32'(count_reg) > MAX_PARTITIONS) ? CNT_W'(MAX_PARTITIONS)
                                                    : CNT_W'(count_reg);

    // Next fit resumes at the last placement; a stale pointer restarts at zero
    assign start_idx = (strategy_reg == STRAT_NEXT && CNT_W'(next_ptr_reg) < n_in)
                       ? next_ptr_reg : '0;

    assign issue  = (state_reg == ST_SCAN) && (issued_reg != n_reg);
    assign wb_en  = (state_reg == ST_WRITE) && found_vld_reg;
    assign wb_val = found_val_reg - amount_reg;

    assign size_we   = load_hit;
    assign rem_we    = load_hit || wb_en;
    assign rem_waddr = wb_en ? found_idx_reg : slot_idx;
    assign rem_wdata = wb_en ? wb_val : s_data.amount;

    pfa_ram #(.WIDTH(AMT_W), .DEPTH(MAX_PARTITIONS)) u_size_ram (
        .clk     (aclk),
        .wr_en   (size_we),
        .wr_addr (slot_idx),
        .wr_data (s_data.amount),
        .rd_en   (issue),
        .rd_addr (addr_reg),
        .rd_data (size_rd)
    );

    pfa_ram #(.WIDTH(AMT_W), .DEPTH(MAX_PARTITIONS)) u_rem_ram (
        .clk     (aclk),
        .wr_en   (rem_we),
        .wr_addr (rem_waddr),
        .wr_data (rem_wdata),
        .rd_en   (issue),
        .rd_addr (addr_reg),
        .rd_data (rem_rd)
    );

    // An entry not rewritten since restart holds its size; an unloaded size reads as zero
    assign cur_val = rem_sel_reg[rd_idx_reg] ? rem_rd
                   : (size_vld_reg[rd_idx_reg] ? size_rd : '0);
    assign fits = (cur_val >= amount_reg);

    always_comb begin
        unique case (strategy_reg)
            STRAT_BEST:  take = fits && (!found_vld_reg || cur_val < found_val_reg);
            STRAT_WORST: take = fits && (!found_vld_reg || cur_val > found_val_reg);
            STRAT_LAST:  take = fits;
            default:     take = fits && !found_vld_reg;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        strategy_next  = strategy_reg;
        count_next     = count_reg;
        size_vld_next  = size_vld_reg;
        rem_sel_next   = rem_sel_reg;
        next_ptr_next  = next_ptr_reg;
        rd_vld_next    = issue;
        found_vld_next = found_vld_reg;
        out_vld_next   = out_vld_reg;
        addr_next      = addr_reg;
        issued_next    = issued_reg;
        n_next         = n_reg;
        rd_idx_next    = addr_reg;
        found_idx_next = found_idx_reg;
        found_val_next = found_val_reg;
        amount_next    = amount_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;

        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_STRATEGY: strategy_next = cfg_wdata[STRAT_W-1:0];
                CFG_COUNT:    count_next    = cfg_wdata[COUNT_W-1:0];
                default:      ;
            endcase
        end

        if (m_valid && m_ready) begin
            out_vld_next = 1'b0;
        end

        if (load_hit) begin
            size_vld_next[slot_idx] = 1'b1;
            rem_sel_next[slot_idx]  = 1'b1;
        end
        if (wb_en) begin
            rem_sel_next[found_idx_reg] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    res_next = '0;
                    if (s_data.func == FUNC_RESTART) begin
                        rem_sel_next  = '0;
                        next_ptr_next = '0;
                    end
                    if (s_data.func == FUNC_ALLOC && n_in != '0) begin
                        addr_next      = start_idx;
                        issued_next    = '0;
                        n_next         = n_in;
                        found_vld_next = 1'b0;
                        amount_next    = s_data.amount;
                        state_next     = ST_SCAN;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    issued_next = issued_reg + 1'b1;
                    // wrap at the last partition in use
                    addr_next = (CNT_W'(addr_reg) + 1'b1 == n_reg) ? '0 : addr_reg + 1'b1;
                end
                if (rd_vld_reg && take) begin
                    found_vld_next = 1'b1;
                    found_idx_next = rd_idx_reg;
                    found_val_next = cur_val;
                end
                if (!issue && !rd_vld_reg) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (found_vld_reg) begin
                    res_next.granted          = 1'b1;
                    res_next.chosen_partition = SLOT_W'(found_idx_reg);
                    res_next.remaining_after  = wb_val;
                    if (strategy_reg == STRAT_NEXT) begin
                        next_ptr_next = found_idx_reg;
                    end
                end
                state_next = ST_RESP;
            end
            ST_RESP: begin
                // hold the result until the output register frees
                if (!out_vld_reg || m_ready) begin
                    out_vld_next  = 1'b1;
                    out_data_next = res_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            strategy_reg  <= STRATEGY_RESET;
            count_reg     <= COUNT_RESET;
            size_vld_reg  <= '0;
            rem_sel_reg   <= '0;
            next_ptr_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            found_vld_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            strategy_reg  <= strategy_next;
            count_reg     <= count_next;
            size_vld_reg  <= size_vld_next;
            rem_sel_reg   <= rem_sel_next;
            next_ptr_reg  <= next_ptr_next;
            rd_vld_reg    <= rd_vld_next;
            found_vld_reg <= found_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg      <= addr_next;
        issued_reg    <= issued_next;
        n_reg         <= n_next;
        rd_idx_reg    <= rd_idx_next;
        found_idx_reg <= found_idx_next;
        found_val_reg <= found_val_next;
        amount_reg    <= amount_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
    end

    a_rd_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> (state_reg == ST_SCAN))
        else $error("read data pending outside the scan");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (issued_reg <= n_reg))
        else $error("scan issued more reads than partitions in use");

    a_refused_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.granted) |->
            (m_data.chosen_partition == '0 && m_data.remaining_after == '0))
        else $error("refused result carries a partition or capacity");

    a_grant_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && found_vld_reg) |-> (CNT_W'(found_idx_reg) < n_reg))
        else $error("chosen partition beyond those in use");

endmodule

`default_nettype wire

FILE: test/partition_fit_allocator_tb.sv
// Self-checking testbench for partition_fit_allocator: a behavioural copy of the
// partition table predicts each result, which is checked in order against the DUT.
// Depends on pfa_pkg and the allocator RTL.
module partition_fit_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pfa_pkg::*;

    localparam int NPART        = 16;
    localparam int RANDOM_ITEMS = 1950;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [AMT_W-1:0]  AMT_MAX     = '1;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow of the partition table and configuration
    logic [AMT_W-1:0]   part_size [NPART];
    logic [AMT_W-1:0]   part_left [NPART];
    logic [SLOT_W-1:0]  next_slot    = '0;
    logic [STRAT_W-1:0] cur_strategy = STRATEGY_RESET;
    logic [COUNT_W-1:0] cur_count    = COUNT_RESET;
    out_item_t          grant_q[$];

    int errors     = 0;
    int n_sent     = 0;
    int n_checked  = 0;
    int n_loads    = 0;
    int n_granted  = 0;
    int n_refused  = 0;
    int n_restarts = 0;
    int burst_left = 0;
    int gap_max    = 8;

    logic [15:0] ready_pattern = '1;
    int          pattern_age   = 0;

    partition_fit_allocator #(.MAX_PARTITIONS(NPART)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #8ms;
        $display("Timed out with %0d results outstanding", grant_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Index of the partition the current strategy picks, or -1 when nothing fits
    function automatic int find_partition(logic [AMT_W-1:0] req, int n);
        int found;
        int j;
        found = -1;
        case (cur_strategy)
            STRAT_BEST: begin
                for (int i = 0; i < n; i++)
                    if (part_left[i] >= req && (found < 0 || part_left[i] < part_left[found]))
                        found = i;
            end
            STRAT_WORST: begin
                for (int i = 0; i < n; i++)
                    if (part_left[i] >= req && (found < 0 || part_left[i] > part_left[found]))
                        found = i;
            end
            STRAT_NEXT: begin
                // a pointer left beyond the partitions in use restarts the search at 0
                j = (next_slot < n) ? int'(next_slot) : 0;
                for (int i = 0; i < n && found < 0; i++) begin
                    if (part_left[j] >= req)
                        found = j;
                    j = (j + 1 == n) ? 0 : j + 1;
                end
            end
            STRAT_LAST: begin
                for (int i = n - 1; i >= 0 && found < 0; i--)
                    if (part_left[i] >= req)
                        found = i;
            end
            default: begin
                for (int i = 0; i < n && found < 0; i++)
                    if (part_left[i] >= req)
                        found = i;
            end
        endcase
        return found;
    endfunction

    function automatic out_item_t predict_result(in_item_t r);
        out_item_t res;
        int        n;
        int        k;
        res = '0;
        case (r.func)
            FUNC_LOAD: begin
                part_size[r.slot] = r.amount;
                part_left[r.slot] = r.amount;
                n_loads++;
            end
            FUNC_ALLOC: begin
                n = (cur_count > NPART) ? NPART : int'(cur_count);
                k = find_partition(r.amount, n);
                if (k >= 0) begin
                    part_left[k] = part_left[k] - r.amount;
                    if (cur_strategy == STRAT_NEXT)
                        next_slot = k[SLOT_W-1:0];
                    res.granted          = 1'b1;
                    res.chosen_partition = k[SLOT_W-1:0];
                    res.remaining_after  = part_left[k];
                    n_granted++;
                end else begin
                    n_refused++;
                end
            end
            FUNC_RESTART: begin
                for (int i = 0; i < NPART; i++)
                    part_left[i] = part_size[i];
                next_slot = '0;
                n_restarts++;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [SLOT_W-1:0] slot,
                                input logic [AMT_W-1:0] amount);
        in_item_t r;
        int       gap;
        r = '{func: func, slot: slot, amount: amount};
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        grant_q.push_back(predict_result(r));
        n_sent++;
    endtask

    // Drop valid and hold until every result has come back
    task automatic wait_idle();
        s_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (grant_q.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    // Only called while idle; bits above the strategy field must be ignored
    task automatic set_config(input logic [STRAT_W-1:0] strat, input logic [COUNT_W-1:0] count,
                              input logic [CFG_DATA_W-STRAT_W-1:0] strat_pad);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_STRATEGY;
        cfg_wdata <= {strat_pad, strat};
        @(posedge aclk);
        cfg_addr  <= CFG_COUNT;
        cfg_wdata <= count;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        cur_strategy = strat;
        cur_count    = count;
    endtask

    always @(posedge aclk) begin
        out_item_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            n_checked++;
            if (grant_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0b/%0d/%0d", $time,
                         m_data.granted, m_data.chosen_partition, m_data.remaining_after);
                errors++;
            end else begin
                exp_res = grant_q.pop_front();
                if (m_data.granted !== exp_res.granted) begin
                    $display("%0t: granted expected %0b, got %0b", $time,
                             exp_res.granted, m_data.granted);
                    errors++;
                end
                if (m_data.chosen_partition !== exp_res.chosen_partition) begin
                    $display("%0t: chosen_partition expected %0d, got %0d", $time,
                             exp_res.chosen_partition, m_data.chosen_partition);
                    errors++;
                end
                if (m_data.remaining_after !== exp_res.remaining_after) begin
                    $display("%0t: remaining_after expected %0d, got %0d", $time,
                             exp_res.remaining_after, m_data.remaining_after);
                    errors++;
                end
            end
        end
        // rotate a stall pattern, swapping in a new one each time pattern_age wraps
        if (pattern_age == 63) begin
            pattern_age   <= 0;
            ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom() | 1);
        end else begin
            pattern_age   <= pattern_age + 1;
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
        m_ready <= ready_pattern[0];
    end

    function automatic logic [AMT_W-1:0] pick_size(int scale);
        if ($urandom_range(0, 15) == 0)
            return AMT_MAX;
        return AMT_W'($urandom() & ((32'd1 << scale) - 1));
    endfunction

    function automatic logic [AMT_W-1:0] pick_request(int scale);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 25)
            return part_left[$urandom_range(0, NPART - 1)];
        return AMT_W'($urandom() & (((32'd1 << scale) - 1) >> $urandom_range(0, 3)));
    endfunction

    task automatic test_empty_table();
        send_request(FUNC_ALLOC, 4'd0, '0);
        send_request(FUNC_ALLOC, 4'd15, AMT_MAX);
        send_request(FUNC_UNUSED, 4'd15, AMT_MAX);
        send_request(FUNC_RESTART, 4'd0, '0);
    endtask

    task automatic test_load_and_fit();
        send_request(FUNC_LOAD, 4'd0, AMT_MAX);
        send_request(FUNC_LOAD, 4'd15, 20'h80000);
        send_request(FUNC_LOAD, 4'd5, 20'd100);
        send_request(FUNC_LOAD, 4'd9, 20'd100);
        send_request(FUNC_ALLOC, 4'd0, AMT_MAX);
        send_request(FUNC_ALLOC, 4'd0, 20'd50);
        send_request(FUNC_RESTART, 4'd0, '0);
    endtask

    // One request under each strategy code, unused codes included
    task automatic test_strategies();
        for (int s = 0; s < 8; s++) begin
            wait_idle();
            set_config(STRAT_W'(s), COUNT_RESET, 2'(s));
            send_request(FUNC_ALLOC, 4'd0, 20'd60);
        end
    endtask

    task automatic test_count_extremes();
        wait_idle();
        set_config(STRAT_FIRST, 5'd0, 2'd0);
        send_request(FUNC_ALLOC, 4'd0, '0);
        wait_idle();
        set_config(STRAT_FIRST, 5'd1, 2'd0);
        send_request(FUNC_ALLOC, 4'd0, '0);
        wait_idle();
        set_config(STRAT_LAST, 5'd31, 2'd3);
        send_request(FUNC_ALLOC, 4'd0, '0);
        // move the next-fit pointer to the top, then shrink the count under it
        send_request(FUNC_RESTART, 4'd0, '0);
        wait_idle();
        set_config(STRAT_NEXT, COUNT_RESET, 2'd0);
        send_request(FUNC_ALLOC, 4'd0, 20'h80000);
        send_request(FUNC_ALLOC, 4'd0, 20'h80000);
        wait_idle();
        set_config(STRAT_NEXT, 5'd4, 2'd0);
        send_request(FUNC_ALLOC, 4'd0, '0);
    endtask

    task automatic test_random_traffic();
        int target;
        int roll;
        int scale;
        int phase_len;
        logic [COUNT_W-1:0] count;
        target = n_sent + RANDOM_ITEMS;
        while (n_sent < target) begin
            wait_idle();
            roll = $urandom_range(0, 9);
            if (roll < 4)
                count = COUNT_RESET;
            else if (roll < 8)
                count = COUNT_W'($urandom_range(1, 15));
            else if (roll == 8)
                count = '0;
            else
                count = COUNT_W'($urandom_range(17, 31));
            set_config(STRAT_W'($urandom_range(0, 7)), count, 2'($urandom_range(0, 3)));
            roll = $urandom_range(0, 2);
            gap_max = (roll == 0) ? 0 : (roll == 1) ? 3 : 24;
            scale = $urandom_range(2, AMT_W);
            // fill the table, then work it with requests mixed with some noise
            repeat ($urandom_range(1, 16))
                send_request(FUNC_LOAD, SLOT_W'($urandom()), pick_size(scale));
            send_request(FUNC_RESTART, SLOT_W'($urandom()), AMT_W'($urandom()));
            phase_len = $urandom_range(40, 100);
            repeat (phase_len) begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    send_request(FUNC_ALLOC, SLOT_W'($urandom()), pick_request(scale));
                else if (roll < 80)
                    send_request(FUNC_LOAD, SLOT_W'($urandom()), pick_size(scale));
                else if (roll < 86)
                    send_request(FUNC_RESTART, SLOT_W'($urandom()), AMT_W'($urandom()));
                else if (roll < 90)
                    send_request(FUNC_UNUSED, SLOT_W'($urandom()), AMT_W'($urandom()));
                else
                    send_request(FUNC_ALLOC, SLOT_W'($urandom()), AMT_W'($urandom()));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < NPART; i++) begin
            part_size[i] = '0;
            part_left[i] = '0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_table();
        test_load_and_fit();
        test_strategies();
        test_count_extremes();
        test_random_traffic();
        wait_idle();
        repeat (20) @(posedge aclk);
        $display("Sent %0d requests (%0d loads, %0d restarts); %0d placed, %0d refused",
                 n_sent, n_loads, n_restarts, n_granted, n_refused);
        $display("Checked %0d results over all strategies and partition counts", n_checked);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: partition_fit_allocator.f
src/pfa_pkg.sv
src/pfa_ram.sv
src/partition_fit_allocator.sv
test/partition_fit_allocator_tb.sv
